// File: rtl/cslc_pkg.sv
// ----------------------------------------------------------------------------
// cslc_pkg
// Shared types and constants for the character stream lexer and classifier.
// ----------------------------------------------------------------------------
package cslc_pkg;

  // Token classes.
  localparam logic [3:0] CLS_ARITH    = 4'd0;
  localparam logic [3:0] CLS_ASSIGN   = 4'd1;
  localparam logic [3:0] CLS_REL      = 4'd2;
  localparam logic [3:0] CLS_LOGIC    = 4'd3;
  localparam logic [3:0] CLS_DELIM    = 4'd4;
  localparam logic [3:0] CLS_COMMENT  = 4'd5;
  localparam logic [3:0] CLS_NOISE    = 4'd6;
  localparam logic [3:0] CLS_KEYWORD  = 4'd7;
  localparam logic [3:0] CLS_RESERVED = 4'd8;
  localparam logic [3:0] CLS_FUNC     = 4'd9;
  localparam logic [3:0] CLS_VAR      = 4'd10;
  localparam logic [3:0] CLS_INT      = 4'd11;
  localparam logic [3:0] CLS_FLOAT    = 4'd12;
  localparam logic [3:0] CLS_INVALID  = 4'd13;

  // Pending operator codes.
  localparam logic [2:0] PEND_NONE = 3'd0;
  localparam logic [2:0] PEND_EQ   = 3'd1;
  localparam logic [2:0] PEND_BANG = 3'd2;
  localparam logic [2:0] PEND_GT   = 3'd3;
  localparam logic [2:0] PEND_LT   = 3'd4;
  localparam logic [2:0] PEND_DIV  = 3'd5;

  // Operator and delimiter indexes.
  localparam logic [4:0] OP_PLUS = 5'd0;
  localparam logic [4:0] OP_MINUS = 5'd1;
  localparam logic [4:0] OP_MUL = 5'd2;
  localparam logic [4:0] OP_DIV = 5'd3;
  localparam logic [4:0] OP_MOD = 5'd4;
  localparam logic [4:0] OP_POW = 5'd5;
  localparam logic [4:0] OP_ASSIGN = 5'd6;
  localparam logic [4:0] OP_EQ = 5'd7;
  localparam logic [4:0] OP_NE = 5'd8;
  localparam logic [4:0] OP_GT = 5'd9;
  localparam logic [4:0] OP_GE = 5'd10;
  localparam logic [4:0] OP_LT = 5'd11;
  localparam logic [4:0] OP_LE = 5'd12;
  localparam logic [4:0] OP_AND = 5'd13;
  localparam logic [4:0] OP_OR = 5'd14;
  localparam logic [4:0] OP_LPAR = 5'd15;
  localparam logic [4:0] OP_RPAR = 5'd16;
  localparam logic [4:0] OP_LBRACE = 5'd17;
  localparam logic [4:0] OP_RBRACE = 5'd18;
  localparam logic [4:0] OP_LBRACK = 5'd19;
  localparam logic [4:0] OP_RBRACK = 5'd20;
  localparam logic [4:0] OP_COMMA = 5'd21;
  localparam logic [4:0] OP_COMMENT = 5'd22;

  // One emitted token before line stamping.
  typedef struct packed {
    logic [3:0] cls;
    logic [4:0] id;
    logic [7:0] len;
  } tok_t;

  // One queue entry: up to three tokens caused by one character.
  typedef struct packed {
    logic [1:0]  cnt;
    tok_t [2:0]  tok;
    logic [15:0] line;
  } grp_t;

  // Table word character at position p (zero past the end).
  function automatic logic [7:0] word_char(input logic [4:0] w, input logic [2:0] p);
    logic [47:0] s;
    unique case (w)
      5'd0:  s = {"and", 24'h0};
      5'd1:  s = {"alt", 24'h0};
      5'd2:  s = {"binar", 8'h0};
      5'd3:  s = {"bind", 16'h0};
      5'd4:  s = {"const", 8'h0};
      5'd5:  s = {"craft", 8'h0};
      5'd6:  s = {"deca", 16'h0};
      5'd7:  s = {"disp", 16'h0};
      5'd8:  s = {"dum", 24'h0};
      5'd9:  s = "duplos";
      5'd10: s = {"endo", 16'h0};
      5'd11: s = {"exec", 16'h0};
      5'd12: s = {"false", 8'h0};
      5'd13: s = {"fetch", 8'h0};
      5'd14: s = {"flux", 16'h0};
      5'd15: s = {"for", 24'h0};
      5'd16: s = {"formo", 8'h0};
      5'd17: s = {"from", 16'h0};
      5'd18: s = {"goto", 16'h0};
      5'd19: s = {"null", 16'h0};
      5'd20: s = {"numb", 16'h0};
      5'd21: s = {"opt", 24'h0};
      5'd22: s = {"pro", 24'h0};
      5'd23: s = "quando";
      5'd24: s = {"set", 24'h0};
      5'd25: s = {"signa", 8'h0};
      5'd26: s = "starto";
      5'd27: s = {"to", 32'h0};
      5'd28: s = {"true", 16'h0};
      5'd29: s = {"unset", 8'h0};
      5'd30: s = {"until", 8'h0};
      default: s = {"yield", 8'h0};
    endcase
    unique case (p)
      3'd0: word_char = s[47:40];
      3'd1: word_char = s[39:32];
      3'd2: word_char = s[31:24];
      3'd3: word_char = s[23:16];
      3'd4: word_char = s[15:8];
      3'd5: word_char = s[7:0];
      default: word_char = 8'h0;
    endcase
  endfunction

  function automatic logic [2:0] word_len(input logic [4:0] w);
    logic [2:0] n;
    n = 3'd6;
    for (int p = 5; p >= 0; p--) begin
      if (word_char(w, 3'(p)) == 8'h0) n = 3'(p);
    end
    word_len = n;
  endfunction

  function automatic logic [3:0] word_class(input logic [4:0] w);
    unique case (w)
      5'd0, 5'd15, 5'd17, 5'd27, 5'd30: word_class = CLS_NOISE;
      5'd4, 5'd12, 5'd18, 5'd19, 5'd28: word_class = CLS_RESERVED;
      default: word_class = CLS_KEYWORD;
    endcase
  endfunction

endpackage

// File: rtl/cslc_front.sv
// ----------------------------------------------------------------------------
// cslc_front
// Scanner: tracks the held word and pending operator, and classifies tokens.
// ----------------------------------------------------------------------------
module cslc_front #(
  parameter int MAX_TOKEN = 255,
  parameter int LINE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          ch,
  input  logic                eoi,
  output cslc_pkg::grp_t      grp
);
  import cslc_pkg::*;

  localparam logic [LINE_BITS-1:0] LINE_TOP = {LINE_BITS{1'b1}};

  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic [7:0]  wlen_r, wlen_nxt;
  logic [31:0] cand_r, cand_nxt;
  logic [5:0]  flags_r, flags_nxt;
  logic [15:0] lead_r, lead_nxt;
  logic        skip_r, skip_nxt;

  // Classification of the held word.
  tok_t wtok;
  logic [7:0] c0, c1;
  always_comb begin
    logic hit;
    c0 = lead_r[7:0];
    c1 = lead_r[15:8];
    wtok.len = wlen_r;
    wtok.cls = CLS_INVALID;
    wtok.id = '0;
    hit = 1'b0;
    if (flags_r[5]) begin
      wtok.cls = CLS_INVALID;
    end else if (c0 == "$") begin
      wtok.cls = CLS_COMMENT;
    end else begin
      for (int i = 31; i >= 0; i--) begin
        if (cand_r[i] && {5'd0, word_len(5'(i))} == wlen_r) begin
          wtok.cls = word_class(5'(i));
          wtok.id = 5'(i);
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (wlen_r == 8'd2 && c0 == "&" && c1 == "&") begin
          wtok.cls = CLS_LOGIC;
          wtok.id = OP_AND;
        end else if (wlen_r == 8'd2 && c0 == "|" && c1 == "|") begin
          wtok.cls = CLS_LOGIC;
          wtok.id = OP_OR;
        end else if (c0 == "f" && c1 == "n" && wlen_r >= 8'd4 && flags_r[3] && flags_r[4]
                     && !flags_r[0]) begin
          wtok.cls = CLS_FUNC;
        end else if (c0 == "@" && wlen_r >= 8'd2 && ((c1 >= "a" && c1 <= "z") || c1 == "_")
                     && !flags_r[0]) begin
          wtok.cls = CLS_VAR;
        end else if (c0 >= "0" && c0 <= "9" && !flags_r[1]) begin
          wtok.cls = flags_r[2] ? CLS_FLOAT : CLS_INT;
        end
      end
    end
  end

  // Single-character form of the pending operator.
  tok_t stok;
  logic svalid;
  always_comb begin
    svalid = 1'b1;
    stok.len = 8'd1;
    stok.id = '0;
    stok.cls = CLS_INVALID;
    unique case (pend_r)
      PEND_EQ:   begin stok.cls = CLS_ASSIGN; stok.id = OP_ASSIGN; end
      PEND_BANG: begin stok.cls = CLS_INVALID; end
      PEND_GT:   begin stok.cls = CLS_REL; stok.id = OP_GT; end
      PEND_LT:   begin stok.cls = CLS_REL; stok.id = OP_LT; end
      PEND_DIV:  begin stok.cls = CLS_ARITH; stok.id = OP_DIV; end
      default:   svalid = 1'b0;
    endcase
  end

  // Step logic.
  always_comb begin
    logic [2:0] p;
    logic wflush, wordv, done, cadd, ssingle, opv;
    logic [7:0] pos;
    tok_t op;
    tok_t list [3];
    logic [1:0] n;
    line_nxt = line_r;
    pend_nxt = pend_r;
    wlen_nxt = wlen_r;
    cand_nxt = cand_r;
    flags_nxt = flags_r;
    lead_nxt = lead_r;
    skip_nxt = skip_r;
    grp = '0;
    p = pend_r;
    wflush = 1'b0;
    ssingle = 1'b0;
    opv = 1'b0;
    op = '0;
    cadd = 1'b0;
    done = 1'b0;
    wordv = wlen_r != 8'd0;
    list[0] = '0; list[1] = '0; list[2] = '0;
    n = '0;
    pos = wlen_r;
    if (skip_r) begin
      if (eoi) skip_nxt = 1'b0;
      else if (ch == 8'd10) begin
        skip_nxt = 1'b0;
        if (line_r != LINE_TOP) line_nxt = line_r + 1'b1;
      end
    end else begin
      pend_nxt = PEND_NONE;
      if (eoi) begin
        if (wordv) begin list[n] = wtok; n = n + 1'b1; end
        if (svalid) begin list[n] = stok; n = n + 1'b1; end
        wflush = 1'b1;
      end else begin
        if (p == PEND_DIV) begin
          if (ch == "/") begin
            list[0] = '{cls: CLS_DELIM, id: OP_COMMENT, len: 8'd2};
            n = 2'd1;
            if (wordv) begin list[1] = wtok; n = 2'd2; end
            wflush = 1'b1;
            skip_nxt = 1'b1;
            done = 1'b1;
          end else begin
            if (wordv) begin list[n] = wtok; n = n + 1'b1; end
            list[n] = stok; n = n + 1'b1;
            wflush = 1'b1;
            wordv = 1'b0;
          end
        end else if (p != PEND_NONE) begin
          if (ch == "=") begin
            list[0].len = 8'd2;
            list[0].cls = (p == PEND_EQ) ? CLS_REL : CLS_REL;
            unique case (p)
              PEND_EQ: list[0].id = OP_EQ;
              PEND_BANG: list[0].id = OP_NE;
              PEND_GT: list[0].id = OP_GE;
              default: list[0].id = OP_LE;
            endcase
            n = 2'd1;
            done = 1'b1;
          end else begin
            list[0] = stok;
            n = 2'd1;
          end
        end
        if (!done) begin
          unique case (ch)
            "+": begin opv = 1'b1; op = '{CLS_ARITH, OP_PLUS, 8'd1}; end
            "-": begin opv = 1'b1; op = '{CLS_ARITH, OP_MINUS, 8'd1}; end
            "*": begin opv = 1'b1; op = '{CLS_ARITH, OP_MUL, 8'd1}; end
            "%": begin opv = 1'b1; op = '{CLS_ARITH, OP_MOD, 8'd1}; end
            "^": begin opv = 1'b1; op = '{CLS_ARITH, OP_POW, 8'd1}; end
            "(": begin opv = 1'b1; op = '{CLS_DELIM, OP_LPAR, 8'd1}; end
            ")": begin opv = 1'b1; op = '{CLS_DELIM, OP_RPAR, 8'd1}; end
            "{": begin opv = 1'b1; op = '{CLS_DELIM, OP_LBRACE, 8'd1}; end
            "}": begin opv = 1'b1; op = '{CLS_DELIM, OP_RBRACE, 8'd1}; end
            "[": begin opv = 1'b1; op = '{CLS_DELIM, OP_LBRACK, 8'd1}; end
            "]": begin opv = 1'b1; op = '{CLS_DELIM, OP_RBRACK, 8'd1}; end
            ",": begin opv = 1'b1; op = '{CLS_DELIM, OP_COMMA, 8'd1}; end
            "=": begin ssingle = 1'b1; pend_nxt = PEND_EQ; end
            "!": begin ssingle = 1'b1; pend_nxt = PEND_BANG; end
            ">": begin ssingle = 1'b1; pend_nxt = PEND_GT; end
            "<": begin ssingle = 1'b1; pend_nxt = PEND_LT; end
            "/": pend_nxt = PEND_DIV;
            default: begin
              if (ch == " " || (ch >= 8'd9 && ch <= 8'd13)) begin
                ssingle = 1'b1;
                if (ch == 8'd10 && line_r != LINE_TOP) line_nxt = line_r + 1'b1;
              end else cadd = 1'b1;
            end
          endcase
          if ((opv || ssingle) && wordv) begin
            list[n] = wtok; n = n + 1'b1; wflush = 1'b1;
          end
          if (opv) begin list[n] = op; n = n + 1'b1; end
        end
      end
      // Word update: clear on flush, then append the character if it joins the word.
      if (wflush) begin
        wlen_nxt = '0; cand_nxt = '1; flags_nxt = '0; lead_nxt = '0;
        pos = 8'd0;
      end
      if (cadd) begin
        if (pos >= 8'(MAX_TOKEN)) begin
          flags_nxt[5] = 1'b1;
        end else begin
          for (int i = 0; i < 32; i++) begin
            if (pos >= {5'd0, word_len(5'(i))} || word_char(5'(i), pos[2:0]) != ch)
              cand_nxt[i] = 1'b0;
          end
          if (pos == 8'd0) lead_nxt[7:0] = ch;
          if (pos == 8'd1) lead_nxt[15:8] = ch;
          if (pos >= 8'd1) begin
            if (!((ch >= "0" && ch <= "9") || (ch >= "a" && ch <= "z") ||
                  (ch >= "A" && ch <= "Z") || ch == "_"))
              flags_nxt[0] = 1'b1;
            if (ch == ".") begin
              if (flags_nxt[2]) flags_nxt[1] = 1'b1;
              flags_nxt[2] = 1'b1;
            end else if (!(ch >= "0" && ch <= "9")) flags_nxt[1] = 1'b1;
          end
          if (pos == 8'd2 && ch == "_") flags_nxt[3] = 1'b1;
          if (pos == 8'd3 && ch >= "a" && ch <= "z") flags_nxt[4] = 1'b1;
          wlen_nxt = pos + 8'd1;
        end
      end
    end
    grp.cnt = n;
    grp.tok[0] = list[0];
    grp.tok[1] = list[1];
    grp.tok[2] = list[2];
    if (line_r > LINE_BITS'(16'hFFFF)) grp.line = 16'hFFFF;
    else grp.line = 16'(line_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= LINE_BITS'(1);
      pend_r <= PEND_NONE;
      wlen_r <= '0;
      cand_r <= '1;
      flags_r <= '0;
      lead_r <= '0;
      skip_r <= 1'b0;
    end else if (step) begin
      line_r <= line_nxt;
      pend_r <= pend_nxt;
      wlen_r <= wlen_nxt;
      cand_r <= cand_nxt;
      flags_r <= flags_nxt;
      lead_r <= lead_nxt;
      skip_r <= skip_nxt;
    end
  end

endmodule

// File: rtl/cslc_queue.sv
// ----------------------------------------------------------------------------
// cslc_queue
// Four-entry queue of token groups between scanner and output sequencer.
// ----------------------------------------------------------------------------
module cslc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  cslc_pkg::grp_t wdata,
  input  logic           rd,
  output cslc_pkg::grp_t rdata,
  output logic           empty,
  output logic           full
);
  import cslc_pkg::*;

  grp_t mem [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign empty = cnt_r == 3'd0;
  assign full  = cnt_r == 3'd4;
  assign rdata = mem[rp_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wdata;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, wr} - {2'b0, rd};
    end
  end

endmodule

// File: rtl/cslc_back.sv
// ----------------------------------------------------------------------------
// cslc_back
// Output sequencer: sends the tokens of each group one per transaction.
// ----------------------------------------------------------------------------
module cslc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  cslc_pkg::grp_t q_data,
  output logic           q_rd,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [3:0]     out_token_class,
  output logic [4:0]     out_lexeme_id,
  output logic [15:0]    out_line_number,
  output logic [7:0]     out_token_length,
  output logic           out_last
);
  import cslc_pkg::*;

  logic [1:0] idx_r;
  tok_t cur;
  logic fire;

  always_comb begin
    unique case (idx_r)
      2'd0: cur = q_data.tok[0];
      2'd1: cur = q_data.tok[1];
      default: cur = q_data.tok[2];
    endcase
  end

  assign out_valid = !q_empty;
  assign out_token_class = cur.cls;
  assign out_lexeme_id = cur.id;
  assign out_line_number = q_data.line;
  assign out_token_length = cur.len;
  assign out_last = (idx_r + 2'd1) == q_data.cnt;
  assign fire = out_valid && !out_stall;
  assign q_rd = fire && out_last;

  // Token index within the head group.
  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else if (q_rd) idx_r <= '0;
    else if (fire) idx_r <= idx_r + 2'd1;
  end

endmodule

// File: rtl/char_stream_lexer_classifier.sv
// ----------------------------------------------------------------------------
// char_stream_lexer_classifier
// Character lexer: scanner feeds a token group queue, sequencer emits tokens.
// Path: each token group is registered in the queue before the sequencer sends it.
// Throughput: one character per cycle unless the queue is full; a character
// causing k tokens takes k output transfers, absorbed by the four-group queue.
// Reset: synchronous active low; line count one, no word or operator held.
// ----------------------------------------------------------------------------
module char_stream_lexer_classifier #(
  parameter int MAX_TOKEN = 255,
  parameter int LINE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_class,
  output logic [4:0]  out_lexeme_id,
  output logic [15:0] out_line_number,
  output logic [7:0]  out_token_length,
  output logic        out_last
);
  import cslc_pkg::*;

  grp_t g, qd;
  logic step, full, empty, qrd;

  assign in_stall = full;
  assign step = in_valid && !full;

  cslc_front #(.MAX_TOKEN(MAX_TOKEN), .LINE_BITS(LINE_BITS)) u_front (
    .clk, .rst_n, .step, .ch(in_ch), .eoi(in_end_of_input), .grp(g)
  );

  // Groups with no tokens are not queued.
  cslc_queue u_queue (
    .clk, .rst_n, .wr(step && g.cnt != 2'd0), .wdata(g), .rd(qrd), .rdata(qd),
    .empty, .full
  );

  cslc_back u_back (
    .clk, .rst_n, .q_empty(empty), .q_data(qd), .q_rd(qrd), .out_valid, .out_stall,
    .out_token_class, .out_lexeme_id, .out_line_number, .out_token_length, .out_last
  );

endmodule
